// File: rtl/smi_pkg.sv
// shared types, constants and sine table for the stepper microstep indexer
package smi_pkg;

  localparam int QUARTER_STEPS = 32;
  localparam int PERIOD        = 4 * QUARTER_STEPS;
  localparam int PHASE_BITS    = $clog2(PERIOD);
  localparam int INDEX_BITS    = $clog2(QUARTER_STEPS + 1);
  localparam int STEP_BITS     = $clog2(QUARTER_STEPS + 1);
  localparam int DUTY_BITS     = 10;
  localparam int POSITION_BITS = 24;
  localparam int DEADBAND_BITS = 8;
  localparam int SHIFT_BITS    = 3;
  localparam int CFG_BITS      = 24;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [DUTY_BITS-1:0] DUTY_FULL = 10'd1023;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SETPOINT  = 2'd0,
    REG_DEADBAND  = 2'd1,
    REG_SHIFT     = 2'd2,
    REG_CLOCKWISE = 2'd3
  } cfg_reg_t;

  // coil polarity codes
  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_t;

  // floor(1023 * sin(k * pi / 64)), k = 0..32
  function automatic logic [DUTY_BITS-1:0] sine_rom(input logic [INDEX_BITS-1:0] k);
    logic [DUTY_BITS-1:0] v;
    case (k)
      6'd0:  v = 10'd0;
      6'd1:  v = 10'd50;
      6'd2:  v = 10'd100;
      6'd3:  v = 10'd150;
      6'd4:  v = 10'd199;
      6'd5:  v = 10'd248;
      6'd6:  v = 10'd296;
      6'd7:  v = 10'd344;
      6'd8:  v = 10'd391;
      6'd9:  v = 10'd437;
      6'd10: v = 10'd482;
      6'd11: v = 10'd525;
      6'd12: v = 10'd568;
      6'd13: v = 10'd609;
      6'd14: v = 10'd648;
      6'd15: v = 10'd687;
      6'd16: v = 10'd723;
      6'd17: v = 10'd757;
      6'd18: v = 10'd790;
      6'd19: v = 10'd821;
      6'd20: v = 10'd850;
      6'd21: v = 10'd877;
      6'd22: v = 10'd902;
      6'd23: v = 10'd924;
      6'd24: v = 10'd945;
      6'd25: v = 10'd963;
      6'd26: v = 10'd978;
      6'd27: v = 10'd992;
      6'd28: v = 10'd1003;
      6'd29: v = 10'd1011;
      6'd30: v = 10'd1018;
      6'd31: v = 10'd1021;
      6'd32: v = 10'd1023;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/stepper_microstep_indexer.sv
// stepper microstep indexer: setpoint tracking, sine/cosine coil duties and polarities
//
// each input word is one timer tick. the block keeps the rotor position in
// 1.8/32 degree units and compares it with the setpoint; when the absolute
// error is above the deadband it takes one microstep of 32 >> shift (at least
// one), advancing the electrical phase (period 128) and moving the position
// down when turning clockwise, up otherwise. coil duties come from a mirrored
// quarter-wave sine table, coil a from |sin| and coil b from |cos|, with
// polarities from the sign of sin (negated clockwise) and of -cos. inside the
// deadband both coils are held at full duty and the polarities stay as they
// were. a tick with zero_position set clears the position before the
// decision. while the output is not stalled one tick is accepted every clock:
// the whole update is a single combinational pass from the state registers into
// the output register, so each word appears in the cycle after its tick. a new
// tick is taken in the same cycle the previous word leaves; while a word waits
// on m_tready the input stalls. configuration is written through cfg_we /
// cfg_index / cfg_data and takes effect on the next tick.
module stepper_microstep_indexer
  import smi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  // tick stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [0] zero_position, rest zero
  // coil command stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [9:0] coil_a_duty, [19:10] coil_b_duty, [21:20] coil_a_drive,
  // [23:22] coil_b_drive, [24] holding, [48:25] tracked_position,
  // [55:49] phase_index
  output logic [55:0]             m_tdata
);

  // configuration registers
  logic signed [POSITION_BITS-1:0] setpoint;
  logic [DEADBAND_BITS-1:0]        deadband;
  logic [SHIFT_BITS-1:0]           shift;
  logic                            clockwise;

  // tracking state
  logic [POSITION_BITS-1:0] position;
  logic [PHASE_BITS-1:0]    phase;
  drive_t                   pol_a;
  drive_t                   pol_b;

  // tick datapath
  logic                     s_accept;
  logic                     m_accept;
  logic [POSITION_BITS-1:0] pos_base;
  logic signed [POSITION_BITS:0] err;
  logic [POSITION_BITS:0]   mag;
  logic                     move;
  logic [STEP_BITS-1:0]     step;
  logic [PHASE_BITS-1:0]    phase_step;
  logic [INDEX_BITS-1:0]    idx;
  drive_t                   pol_a_step;
  drive_t                   pol_b_step;
  logic [DUTY_BITS-1:0]     duty_a_step;
  logic [DUTY_BITS-1:0]     duty_b_step;

  logic [POSITION_BITS-1:0] position_next;
  logic [PHASE_BITS-1:0]    phase_next;
  drive_t                   pol_a_next;
  drive_t                   pol_b_next;
  logic [DUTY_BITS-1:0]     duty_a_next;
  logic [DUTY_BITS-1:0]     duty_b_next;

  // output register
  logic [DUTY_BITS-1:0]     out_duty_a;
  logic [DUTY_BITS-1:0]     out_duty_b;
  drive_t                   out_drive_a;
  drive_t                   out_drive_b;
  logic                     out_hold;
  logic [POSITION_BITS-1:0] out_position;
  logic [PHASE_BITS-1:0]    out_phase;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= '0;
      deadband  <= DEADBAND_BITS'(1);
      shift     <= '0;
      clockwise <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:  setpoint  <= cfg_data[POSITION_BITS-1:0];
        REG_DEADBAND:  deadband  <= cfg_data[DEADBAND_BITS-1:0];
        REG_SHIFT:     shift     <= cfg_data[SHIFT_BITS-1:0];
        REG_CLOCKWISE: clockwise <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // error against the setpoint, exact in one extra bit
  always_comb begin
    pos_base = s_tdata[0] ? '0 : position;
    err      = {setpoint[POSITION_BITS-1], setpoint}
             - {pos_base[POSITION_BITS-1], pos_base};
    mag      = err[POSITION_BITS] ? (POSITION_BITS+1)'(-err) : err;
    move     = mag > {{(POSITION_BITS+1-DEADBAND_BITS){1'b0}}, deadband};
  end

  // microstep: phase advance, quadrant mirror, table lookup, polarities
  always_comb begin
    step = STEP_BITS'(QUARTER_STEPS) >> shift;
    if (step == '0) begin
      step = STEP_BITS'(1);
    end
    phase_step = phase + PHASE_BITS'(step);

    if (phase_step <= PHASE_BITS'(QUARTER_STEPS)) begin
      idx = INDEX_BITS'(phase_step);
    end else if (phase_step <= PHASE_BITS'(2*QUARTER_STEPS)) begin
      idx = INDEX_BITS'(PHASE_BITS'(2*QUARTER_STEPS) - phase_step);
    end else if (phase_step <= PHASE_BITS'(3*QUARTER_STEPS)) begin
      idx = INDEX_BITS'(phase_step - PHASE_BITS'(2*QUARTER_STEPS));
    end else begin
      idx = INDEX_BITS'((PHASE_BITS+1)'(PERIOD) - {1'b0, phase_step});
    end
    duty_a_step = sine_rom(idx);
    duty_b_step = sine_rom(INDEX_BITS'(QUARTER_STEPS) - idx);

    // coil a follows sin, flipped when turning clockwise
    if (phase_step == '0 || phase_step == PHASE_BITS'(2*QUARTER_STEPS)) begin
      pol_a_step = DRIVE_OFF;
    end else if ((phase_step < PHASE_BITS'(2*QUARTER_STEPS)) != clockwise) begin
      pol_a_step = DRIVE_FWD;
    end else begin
      pol_a_step = DRIVE_REV;
    end

    // coil b follows -cos
    if (phase_step == PHASE_BITS'(QUARTER_STEPS)
        || phase_step == PHASE_BITS'(3*QUARTER_STEPS)) begin
      pol_b_step = DRIVE_OFF;
    end else if (phase_step < PHASE_BITS'(QUARTER_STEPS)
                 || phase_step > PHASE_BITS'(3*QUARTER_STEPS)) begin
      pol_b_step = DRIVE_REV;
    end else begin
      pol_b_step = DRIVE_FWD;
    end
  end

  // step or hold
  always_comb begin
    if (move) begin
      position_next = clockwise ? pos_base - POSITION_BITS'(step)
                                : pos_base + POSITION_BITS'(step);
      phase_next    = phase_step;
      pol_a_next    = pol_a_step;
      pol_b_next    = pol_b_step;
      duty_a_next   = duty_a_step;
      duty_b_next   = duty_b_step;
    end else begin
      position_next = pos_base;
      phase_next    = phase;
      pol_a_next    = pol_a;
      pol_b_next    = pol_b;
      duty_a_next   = DUTY_FULL;
      duty_b_next   = DUTY_FULL;
    end
  end

  // tracking state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      phase    <= '0;
      pol_a    <= DRIVE_OFF;
      pol_b    <= DRIVE_OFF;
    end else if (s_accept) begin
      position <= position_next;
      phase    <= phase_next;
      pol_a    <= pol_a_next;
      pol_b    <= pol_b_next;
    end
  end

  // output register, refilled whenever a tick is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_accept) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_duty_a   <= duty_a_next;
      out_duty_b   <= duty_b_next;
      out_drive_a  <= pol_a_next;
      out_drive_b  <= pol_b_next;
      out_hold     <= !move;
      out_position <= position_next;
      out_phase    <= phase_next;
    end
  end

  assign m_tdata = {out_phase, out_position, out_hold, out_drive_b, out_drive_a,
                    out_duty_b, out_duty_a};

  // a held word always drives both coils at full
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_hold |-> out_duty_a == DUTY_FULL && out_duty_b == DUTY_FULL)
    else $error("holding word without full coil duty");

  // every microstep moves the phase
  a_step_moves_phase: assert property (@(posedge clk) disable iff (rst)
    s_accept && move |=> phase != $past(phase))
    else $error("microstep left the phase unchanged");

  // a hold keeps phase and polarities
  a_hold_keeps_state: assert property (@(posedge clk) disable iff (rst)
    s_accept && !move |=> $stable(phase) && $stable(pol_a) && $stable(pol_b))
    else $error("hold changed phase or polarity");

  // the output word mirrors the tracking state it was built from
  a_word_matches_state: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> out_phase == phase && out_position == position
                 && out_drive_a == pol_a && out_drive_b == pol_b)
    else $error("output word out of step with tracking state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// File: tb/stepper_microstep_indexer_tb.sv
// testbench for the stepper microstep indexer: directed corners, random moves, stalls, wrap
`timescale 1ns / 100ps

module stepper_microstep_indexer_tb;
  import smi_pkg::*;

  // one coil command word, laid out as on m_tdata (last field in the lowest bits)
  typedef struct packed {
    logic [6:0]               phase_index;
    logic [POSITION_BITS-1:0] tracked_position;
    logic                     holding;
    drive_t                   coil_b_drive;
    drive_t                   coil_a_drive;
    logic [DUTY_BITS-1:0]     coil_b_duty;
    logic [DUTY_BITS-1:0]     coil_a_duty;
  } coil_word_t;

  // cycles without any accepted word before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata = '0;     // [0] zero_position, rest zero
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // [9:0] coil_a_duty, [19:10] coil_b_duty, [21:20] coil_a_drive,
  // [23:22] coil_b_drive, [24] holding, [48:25] tracked_position,
  // [55:49] phase_index
  logic [55:0]             m_tdata;

  stepper_microstep_indexer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // quarter-wave duty table, filled at time zero from the fixed-point sine series
  longint unsigned sine_lut [0:QUARTER_STEPS];

  // register copies, at their reset values
  logic signed [POSITION_BITS-1:0] set_pos     = '0;
  logic [DEADBAND_BITS-1:0]        dead_band   = 8'd1;
  logic [SHIFT_BITS-1:0]           ustep_shift = '0;
  logic                            cw_dir      = 1'b1;

  // rotor state as the block should track it
  logic signed [POSITION_BITS-1:0] track_pos  = '0;
  int                              elec_phase = 0;
  drive_t                          pol_a      = DRIVE_OFF;
  drive_t                          pol_b      = DRIVE_OFF;

  coil_word_t pending_words[$];

  int  mismatches    = 0;
  int  ticks_in      = 0;
  int  words_checked = 0;
  int  held_ticks    = 0;
  int  pos_wraps     = 0;
  int  quiet_cycles  = 0;
  bit  src_gaps      = 1'b0;
  bit  sink_gaps     = 1'b0;
  int  hold_off_cycles = 0;

  // microstep size for a shift, never below one
  function automatic int microstep_size(input logic [SHIFT_BITS-1:0] sh);
    int stp;
    stp = QUARTER_STEPS >> sh;
    return (stp == 0) ? 1 : stp;
  endfunction

  function automatic drive_t polarity_of(input int sgn);
    return (sgn > 0) ? DRIVE_FWD : ((sgn < 0) ? DRIVE_REV : DRIVE_OFF);
  endfunction

  // one timer tick: decide hold or microstep, update the tracked state
  function automatic coil_word_t advance_tick(input logic zero);
    coil_word_t w;
    int err, mag, stp, p, i, sa, sb;
    logic signed [POSITION_BITS-1:0] nxt;
    if (zero)
      track_pos = '0;
    // error taken exactly on the sign-extended values
    err = int'(set_pos) - int'(track_pos);
    mag = (err < 0) ? -err : err;
    if (mag > int'(dead_band)) begin
      stp = microstep_size(ustep_shift);
      elec_phase = (elec_phase + stp) % PERIOD;
      p = elec_phase;
      // mirror the phase into the quarter wave
      if (p <= QUARTER_STEPS)
        i = p;
      else if (p <= 2 * QUARTER_STEPS)
        i = 2 * QUARTER_STEPS - p;
      else if (p <= 3 * QUARTER_STEPS)
        i = p - 2 * QUARTER_STEPS;
      else
        i = 4 * QUARTER_STEPS - p;
      w.coil_a_duty = DUTY_BITS'(sine_lut[i]);
      w.coil_b_duty = DUTY_BITS'(sine_lut[QUARTER_STEPS - i]);
      // coil a follows sin, coil b follows -cos; zero on the quadrant edges
      sa = (p == 0 || p == 2 * QUARTER_STEPS) ? 0 : ((p < 2 * QUARTER_STEPS) ? 1 : -1);
      if (cw_dir)
        sa = -sa;
      sb = (p == QUARTER_STEPS || p == 3 * QUARTER_STEPS) ? 0 :
           ((p < QUARTER_STEPS || p > 3 * QUARTER_STEPS) ? -1 : 1);
      pol_a = polarity_of(sa);
      pol_b = polarity_of(sb);
      nxt = cw_dir ? track_pos - POSITION_BITS'(stp) : track_pos + POSITION_BITS'(stp);
      // borrow or carry out of the raw position word
      if (cw_dir ? ($unsigned(nxt) > $unsigned(track_pos))
                 : ($unsigned(nxt) < $unsigned(track_pos)))
        pos_wraps++;
      track_pos = nxt;
      w.holding = 1'b0;
    end else begin
      // inside the deadband: full duty on both coils, polarities kept
      w.coil_a_duty = DUTY_FULL;
      w.coil_b_duty = DUTY_FULL;
      w.holding = 1'b1;
      held_ticks++;
    end
    w.coil_a_drive     = pol_a;
    w.coil_b_drive     = pol_b;
    w.tracked_position = track_pos;
    w.phase_index      = 7'(elec_phase);
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // predict on every accepted tick, compare every accepted coil word,
  // and watch for a stretch with nothing moving on either side
  always @(posedge clk) begin
    coil_word_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_words.push_back(advance_tick(s_tdata[0]));
        ticks_in++;
      end
      if (m_tvalid && m_tready) begin
        got = coil_word_t'(m_tdata);
        if (pending_words.size() == 0) begin
          $display("%0t ns: coil word with no tick waiting, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("coil_a_duty", want.coil_a_duty, got.coil_a_duty);
          check_field("coil_b_duty", want.coil_b_duty, got.coil_b_duty);
          check_field("coil_a_drive", want.coil_a_drive, got.coil_a_drive);
          check_field("coil_b_drive", want.coil_b_drive, got.coil_b_drive);
          check_field("holding", want.holding, got.holding);
          check_field("tracked_position", want.tracked_position, got.tracked_position);
          check_field("phase_index", want.phase_index, got.phase_index);
          words_checked++;
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no word accepted for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: ready runs, random stall bursts, and a long hold-off on request
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // offer one tick, maybe after an idle burst, and wait for it to be taken
  task automatic push_tick(input logic zero);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, zero};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and let every outstanding coil word come back
  task automatic drain_ticks();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
    drain_ticks();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT:  set_pos     = val[POSITION_BITS-1:0];
      REG_DEADBAND:  dead_band   = val[DEADBAND_BITS-1:0];
      REG_SHIFT:     ustep_shift = val[SHIFT_BITS-1:0];
      REG_CLOCKWISE: cw_dir      = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [POSITION_BITS-1:0] sp, input logic [7:0] db,
                           input logic [2:0] sh, input logic cw);
    write_reg(REG_SETPOINT, CFG_BITS'(sp));
    write_reg(REG_DEADBAND, CFG_BITS'(db));
    write_reg(REG_SHIFT, CFG_BITS'(sh));
    write_reg(REG_CLOCKWISE, CFG_BITS'(cw));
  endtask

  // reset values: zero error against a zero setpoint holds, coil drives off
  task automatic test_reset_hold();
    push_tick(1'b0);
    push_tick(1'b1);
  endtask

  // quadrant edges both ways, setpoint and deadband extremes,
  // shifts 0, 5, 6 and 7 including the ones that leave a zero step, off-grid phase
  task automatic test_directed_corners();
    configure(24'd100, 8'd0, 3'd0, 1'b0);
    repeat (5) push_tick(1'b0);
    write_reg(REG_CLOCKWISE, CFG_BITS'(1));
    repeat (4) push_tick(1'b1);
    configure(24'h800000, 8'd255, 3'd7, 1'b1);
    repeat (3) push_tick(1'b0);
    write_reg(REG_SHIFT, CFG_BITS'(6));
    push_tick(1'b0);
    write_reg(REG_SHIFT, CFG_BITS'(5));
    push_tick(1'b0);
    // phase now sits between grid points of the full step
    write_reg(REG_SHIFT, CFG_BITS'(0));
    repeat (2) push_tick(1'b0);
    write_reg(REG_SETPOINT, CFG_BITS'(24'h7FFFFF));
    repeat (2) push_tick(1'b1);
  endtask

  // mostly seek moves that settle into the deadband, some pure noise
  task automatic test_random_moves(input int phases, input int per_phase);
    int stp, seek_dist, zero_odds;
    logic [2:0] sh;
    logic cw;
    logic [7:0] db;
    logic [POSITION_BITS-1:0] sp;
    for (int ph = 0; ph < phases; ph++) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      sh = 3'($urandom_range(0, 7));
      cw = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) begin
        // deadband of at least half a step so the approach lands inside it
        stp       = microstep_size(sh);
        db        = 8'($urandom_range((stp + 1) / 2, 255));
        seek_dist = stp * $urandom_range(0, 50) + $urandom_range(0, 300);
        sp        = POSITION_BITS'(int'(track_pos) + (cw ? -seek_dist : seek_dist));
        zero_odds = 40;
      end else begin
        case ($urandom_range(0, 2))
          0: db = 8'd0;
          1: db = 8'd255;
          default: db = 8'($urandom_range(0, 255));
        endcase
        sp = POSITION_BITS'($urandom());
        zero_odds = 3;
      end
      configure(sp, db, sh, cw);
      repeat (per_phase) push_tick($urandom_range(1, zero_odds) == 1);
    end
  endtask

  // receiver holds off long enough that the block must stall its input
  task automatic test_output_backpressure();
    configure(POSITION_BITS'($urandom()), 8'd0, 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_off_cycles = 300;
    repeat (40) push_tick($urandom_range(0, 7) == 0);
  endtask

  // full steps down through zero so the raw position word borrows,
  // then back up through zero so it carries
  task automatic test_position_wrap();
    configure(24'hFFFF00, 8'd0, 3'd0, 1'b1);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    push_tick(1'b1);
    repeat (10) push_tick(1'b0);
    configure(24'd64, 8'd0, 3'd0, 1'b0);
    repeat (12) push_tick(1'b0);
  endtask

  initial begin
    longint unsigned x, x2, term;
    longint sum;
    // sine table: taylor series in q30, truncated after every multiply and divide
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      x    = (longint'(k) * 64'd1686629713) / QUARTER_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1)
          sum -= longint'(term);
        else
          sum += longint'(term);
      end
      if (sum < 0)
        sum = 0;
      if (sum > (64'd1 << 30))
        sum = 64'd1 << 30;
      sine_lut[k] = (64'd1023 * longint'(sum)) >> 30;
    end
    sine_lut[0] = 0;
    sine_lut[QUARTER_STEPS] = DUTY_FULL;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_hold();
    test_directed_corners();
    test_random_moves(10, 68);
    test_output_backpressure();
    test_position_wrap();

    drain_ticks();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks, %0d coil words compared, %0d of them holding",
             ticks_in, words_checked, held_ticks);
    $display("raw position word wrapped %0d times; receiver long hold-off exercised once",
             pos_wraps);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: stepper_microstep_indexer.f
rtl/smi_pkg.sv
rtl/stepper_microstep_indexer.sv
tb/stepper_microstep_indexer_tb.sv
